// ===== design/keyed_tumbling_window_stats_top_assert.svh =====
// assertion macros for the keyed tumbling window stats block
`ifndef KEYED_TUMBLING_WINDOW_STATS_TOP_ASSERT_SVH
`define KEYED_TUMBLING_WINDOW_STATS_TOP_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define KWS_ASSERT_NOW(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("kws port check failed");

// next-cycle implication, sampled on clock, off during reset
`define KWS_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("kws port check failed");

`endif

// ===== design/kws_pkg.sv =====
// shared types and constants of the keyed tumbling window stats block
package kws_pkg;

   localparam int SLOT_W     = 10;
   localparam int TIME_W     = 63;
   localparam int STATUS_W   = 2;
   localparam int QTY_W      = 32;
   localparam int SEQ_W      = 63;
   localparam int CNT_W      = 32;
   localparam int SUM_W      = 63;
   localparam int Q16_W      = 48;
   localparam int WLEN_W     = 40;
   localparam int MINO_W     = 32;
   localparam int PER_W      = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 40;
   localparam int NSEC_W     = 30;
   localparam int PROD_W     = 62;
   localparam int DIV_NUM_W  = 79;
   localparam int DIV_DEN_W  = 40;
   localparam int DIV_REM_W  = 41;
   localparam int DIV_STEP_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_WINDOW_LENGTH = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_ORDERS    = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EMIT_PERIOD   = 2'd2;

   localparam logic [WLEN_W-1:0] WLEN_RESET = 40'd60000000000;
   localparam logic [MINO_W-1:0] MINO_RESET = 32'd10;
   localparam logic [PER_W-1:0]  PER_RESET  = 16'd1;

   localparam logic [NSEC_W-1:0] NS_PER_SEC = 30'd1000000000;

   localparam logic [STATUS_W-1:0] STATUS_NEW    = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_CANCEL = 2'd1;

   // divider step counts for each quotient
   localparam logic [DIV_STEP_W-1:0] STEPS_MOD  = 7'd32;
   localparam logic [DIV_STEP_W-1:0] STEPS_AVG  = 7'd79;
   localparam logic [DIV_STEP_W-1:0] STEPS_CAN  = 7'd48;
   localparam logic [DIV_STEP_W-1:0] STEPS_RATE = 7'd78;

   typedef enum logic [1:0] {
      KIND_NEW,
      KIND_CANCEL,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [TIME_W-1:0] event_time_ns;
      kind_type          kind;
      logic [QTY_W-1:0]  quantity;
      logic [SEQ_W-1:0]  book_seq;
   } item_type;

   typedef struct packed {
      logic [WLEN_W-1:0] window_length_ns;
      logic [MINO_W-1:0] min_orders;
      logic [PER_W-1:0]  emit_period;
   } cfg_type;

   typedef struct packed {
      logic empty;
      logic full;
   } fifo_stat_type;

   typedef struct packed {
      logic [CNT_W-1:0] orders;
      logic [SUM_W-1:0] qty_sum;
      logic [CNT_W-1:0] cancels;
   } tally_type;

   typedef struct packed {
      logic                  start;
      logic [DIV_NUM_W-1:0]  num;
      logic [DIV_DEN_W-1:0]  den;
      logic [DIV_STEP_W-1:0] steps;
   } div_req_type;

   typedef struct packed {
      logic                 done;
      logic [Q16_W-1:0]     quot;
      logic [DIV_REM_W-1:0] rem;
   } div_rsp_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_UPDATE,
      S_MUL,
      S_OP,
      S_WAIT,
      S_EMIT
   } back_state_type;

   typedef enum logic [1:0] {
      OP_MOD,
      OP_AVG,
      OP_CAN,
      OP_RATE
   } op_type;

endpackage

// ===== design/kws_fifo.sv =====
// two-entry word queue between front and back
module kws_fifo (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  kws_pkg::item_type       push_item,
   input  logic                    pop,
   output kws_pkg::item_type       head_item,
   output kws_pkg::fifo_stat_type  stat
);

   kws_pkg::item_type entry_ff [2];
   logic              wr_ptr_ff, wr_ptr_in;
   logic              rd_ptr_ff, rd_ptr_in;
   logic [1:0]        count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

   assign head_item  = entry_ff[rd_ptr_ff];
   assign stat.empty = (count_ff == 2'd0);
   assign stat.full  = (count_ff == 2'd2);

endmodule

// ===== design/kws_front.sv =====
// front end: accepts request words, drops out-of-range slots, classifies status
module kws_front #(
   parameter int NUM_KEYS = 1024
) (
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [kws_pkg::SLOT_W-1:0]       req_key_slot,
   input  logic [kws_pkg::TIME_W-1:0]       req_event_time_ns,
   input  logic [kws_pkg::STATUS_W-1:0]     req_order_status,
   input  logic [kws_pkg::QTY_W-1:0]        req_quantity,
   input  logic [kws_pkg::SEQ_W-1:0]        req_book_seq,
   input  logic                             clearing,
   input  kws_pkg::fifo_stat_type           fifo_stat,
   output logic                             push,
   output kws_pkg::item_type                push_item
);

   logic in_range;
   logic accept;

   assign req_stall = clearing | fifo_stat.full;
   assign accept    = req_valid & ~req_stall;
   assign in_range  = (32'(req_key_slot) < NUM_KEYS);
   assign push      = accept & in_range;

   always_comb begin
      push_item.slot          = req_key_slot;
      push_item.event_time_ns = req_event_time_ns;
      push_item.quantity      = req_quantity;
      push_item.book_seq      = req_book_seq;
      if (req_order_status == kws_pkg::STATUS_NEW) begin
         push_item.kind = kws_pkg::KIND_NEW;
      end else if (req_order_status == kws_pkg::STATUS_CANCEL) begin
         push_item.kind = kws_pkg::KIND_CANCEL;
      end else begin
         push_item.kind = kws_pkg::KIND_OTHER;
      end
   end

endmodule

// ===== design/kws_div.sv =====
// radix-2 restoring divider, one quotient bit a cycle, 48-bit saturating quotient
module kws_div (
   input  logic                  clock,
   input  logic                  reset,
   input  kws_pkg::div_req_type  req,
   output kws_pkg::div_rsp_type  rsp
);

   logic [kws_pkg::DIV_NUM_W-1:0]  num_ff, num_in;
   logic [kws_pkg::DIV_DEN_W-1:0]  den_ff;
   logic [kws_pkg::DIV_REM_W-1:0]  rem_ff, rem_in;
   logic [kws_pkg::Q16_W-1:0]      quot_ff, quot_in;
   logic                           sat_ff, sat_in;
   logic [kws_pkg::DIV_STEP_W-1:0] cnt_ff;
   logic                           run_ff;
   logic                           done_ff;
   logic [kws_pkg::DIV_REM_W-1:0]  shifted;
   logic                           take;

   always_comb begin
      shifted = {rem_ff[kws_pkg::DIV_REM_W-2:0], num_ff[kws_pkg::DIV_NUM_W-1]};
      take    = (shifted >= {1'b0, den_ff});
      rem_in  = take ? (shifted - {1'b0, den_ff}) : shifted;
      quot_in = {quot_ff[kws_pkg::Q16_W-2:0], take};
      sat_in  = sat_ff | quot_ff[kws_pkg::Q16_W-1];
      num_in  = {num_ff[kws_pkg::DIV_NUM_W-2:0], 1'b0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (req.start) begin
         run_ff  <= 1'b1;
         done_ff <= 1'b0;
         cnt_ff  <= req.steps;
      end else if (run_ff) begin
         cnt_ff  <= cnt_ff - 1'b1;
         run_ff  <= (cnt_ff != 7'd1);
         done_ff <= (cnt_ff == 7'd1);
      end else begin
         done_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         num_ff  <= req.num;
         den_ff  <= req.den;
         rem_ff  <= '0;
         quot_ff <= '0;
         sat_ff  <= 1'b0;
      end else if (run_ff) begin
         num_ff  <= num_in;
         rem_ff  <= rem_in;
         quot_ff <= quot_in;
         sat_ff  <= sat_in;
      end
   end

   assign rsp.done = done_ff;
   assign rsp.quot = sat_ff ? '1 : quot_ff;
   assign rsp.rem  = rem_ff;

endmodule

// ===== design/kws_back.sv =====
// back end: per-slot window update, emit test and record build
module kws_back #(
   parameter int NUM_KEYS = 1024
) (
   input  logic                            clock,
   input  logic                            reset,
   input  kws_pkg::cfg_type                cfg,
   input  kws_pkg::item_type               head_item,
   input  kws_pkg::fifo_stat_type          fifo_stat,
   output logic                            pop,
   output logic                            clearing,
   output kws_pkg::div_req_type            div_req,
   input  kws_pkg::div_rsp_type            div_rsp,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [kws_pkg::SLOT_W-1:0]      rsp_out_slot,
   output logic [kws_pkg::TIME_W-1:0]      rsp_out_time_ns,
   output logic [kws_pkg::SEQ_W-1:0]       rsp_out_book_seq,
   output logic [kws_pkg::CNT_W-1:0]       rsp_window_orders,
   output logic [kws_pkg::SUM_W-1:0]       rsp_window_quantity,
   output logic [kws_pkg::Q16_W-1:0]       rsp_avg_quantity_q16,
   output logic [kws_pkg::Q16_W-1:0]       rsp_cancel_ratio_q16,
   output logic [kws_pkg::Q16_W-1:0]       rsp_order_rate_q16
);

   localparam int IDX_W = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_KEYS - 1);

   kws_pkg::back_state_type state_ff, state_in;
   kws_pkg::op_type         op_ff;
   kws_pkg::item_type       item_ff;

   logic [kws_pkg::TIME_W-1:0] ws_mem_ff [NUM_KEYS];
   kws_pkg::tally_type         tally_mem_ff [NUM_KEYS];
   logic [kws_pkg::TIME_W-1:0] ws_rd_ff;
   kws_pkg::tally_type         tally_rd_ff;
   logic [IDX_W-1:0]           clr_idx_ff;

   logic [kws_pkg::CNT_W-1:0]  n_ff;
   logic [kws_pkg::SUM_W-1:0]  qsum_ff;
   logic [kws_pkg::CNT_W-1:0]  can_ff;
   logic [kws_pkg::PROD_W-1:0] prod_ff;
   logic [kws_pkg::Q16_W-1:0]  avg_ff;
   logic [kws_pkg::Q16_W-1:0]  canr_ff;
   logic [kws_pkg::Q16_W-1:0]  rate_ff;
   logic                       rsp_valid_ff;

   logic [IDX_W-1:0]           rd_idx;
   logic                       restart;
   kws_pkg::tally_type         base;
   kws_pkg::tally_type         tally_new;
   logic [kws_pkg::TIME_W-1:0] start_new;
   logic [kws_pkg::SUM_W:0]    qsum_wide;
   logic                       period_trivial;
   logic                       immediate;
   logic                       out_free;
   logic                       rsp_load;
   logic                       ws_we;
   logic [IDX_W-1:0]           ws_addr;
   logic [kws_pkg::TIME_W-1:0] ws_wdata;
   logic                       tally_we;

   assign rd_idx         = IDX_W'(item_ff.slot);
   assign period_trivial = (cfg.emit_period == 16'd0) || (cfg.emit_period == 16'd1);
   assign out_free       = ~rsp_valid_ff | ~rsp_stall;

   // window restart and tally update
   always_comb begin
      restart = (ws_rd_ff == '0) || (item_ff.event_time_ns < ws_rd_ff) ||
                ((item_ff.event_time_ns - ws_rd_ff) >
                 kws_pkg::TIME_W'(cfg.window_length_ns));
      base      = restart ? '0 : tally_rd_ff;
      start_new = restart ? item_ff.event_time_ns : ws_rd_ff;
      tally_new = base;
      qsum_wide = {1'b0, base.qty_sum} + (kws_pkg::SUM_W + 1)'(item_ff.quantity);
      if (item_ff.kind == kws_pkg::KIND_NEW) begin
         if (base.orders != '1) begin
            tally_new.orders = base.orders + 1'b1;
         end
         tally_new.qty_sum = qsum_wide[kws_pkg::SUM_W] ? '1 :
                             qsum_wide[kws_pkg::SUM_W-1:0];
      end else if (item_ff.kind == kws_pkg::KIND_CANCEL) begin
         if (base.cancels != '1) begin
            tally_new.cancels = base.cancels + 1'b1;
         end
      end
   end

   always_comb begin
      unique case (op_ff)
         kws_pkg::OP_MOD:  immediate = period_trivial;
         kws_pkg::OP_AVG:  immediate = (n_ff == '0);
         kws_pkg::OP_CAN:  immediate = (n_ff == '0);
         kws_pkg::OP_RATE: immediate = (cfg.window_length_ns == '0);
         default:          immediate = 1'b1;
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         kws_pkg::S_CLEAR: begin
            if (clr_idx_ff == LAST_IDX) state_in = kws_pkg::S_IDLE;
         end
         kws_pkg::S_IDLE: begin
            if (!fifo_stat.empty) state_in = kws_pkg::S_READ;
         end
         kws_pkg::S_READ:   state_in = kws_pkg::S_UPDATE;
         kws_pkg::S_UPDATE: state_in = kws_pkg::S_MUL;
         kws_pkg::S_MUL: begin
            state_in = (n_ff < cfg.min_orders) ? kws_pkg::S_IDLE : kws_pkg::S_OP;
         end
         kws_pkg::S_OP: begin
            if (!immediate) begin
               state_in = kws_pkg::S_WAIT;
            end else if (op_ff == kws_pkg::OP_RATE) begin
               state_in = kws_pkg::S_EMIT;
            end
         end
         kws_pkg::S_WAIT: begin
            if (div_rsp.done) begin
               if (op_ff == kws_pkg::OP_MOD) begin
                  state_in = (div_rsp.rem == '0) ? kws_pkg::S_OP : kws_pkg::S_IDLE;
               end else if (op_ff == kws_pkg::OP_RATE) begin
                  state_in = kws_pkg::S_EMIT;
               end else begin
                  state_in = kws_pkg::S_OP;
               end
            end
         end
         kws_pkg::S_EMIT: begin
            if (out_free) state_in = kws_pkg::S_IDLE;
         end
         default: state_in = kws_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop      = (state_ff == kws_pkg::S_IDLE) && !fifo_stat.empty;
      clearing = (state_ff == kws_pkg::S_CLEAR);
      tally_we = (state_ff == kws_pkg::S_UPDATE);
      ws_we    = clearing || tally_we;
      ws_addr  = clearing ? clr_idx_ff : rd_idx;
      ws_wdata = clearing ? '0 : start_new;
      rsp_load = (state_ff == kws_pkg::S_EMIT) && out_free;
      div_req.start = (state_ff == kws_pkg::S_OP) && !immediate;
      unique case (op_ff)
         kws_pkg::OP_MOD: begin
            div_req.num   = {n_ff, 47'b0};
            div_req.den   = kws_pkg::DIV_DEN_W'(cfg.emit_period);
            div_req.steps = kws_pkg::STEPS_MOD;
         end
         kws_pkg::OP_AVG: begin
            div_req.num   = {qsum_ff, 16'b0};
            div_req.den   = kws_pkg::DIV_DEN_W'(n_ff);
            div_req.steps = kws_pkg::STEPS_AVG;
         end
         kws_pkg::OP_CAN: begin
            div_req.num   = {can_ff, 16'b0, 31'b0};
            div_req.den   = kws_pkg::DIV_DEN_W'(n_ff);
            div_req.steps = kws_pkg::STEPS_CAN;
         end
         default: begin
            div_req.num   = {prod_ff, 16'b0, 1'b0};
            div_req.den   = cfg.window_length_ns;
            div_req.steps = kws_pkg::STEPS_RATE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= kws_pkg::S_CLEAR;
         clr_idx_ff <= '0;
      end else begin
         state_ff <= state_in;
         if (clearing) clr_idx_ff <= clr_idx_ff + 1'b1;
      end
   end

   // slot tables
   always_ff @(posedge clock) begin
      if (ws_we) ws_mem_ff[ws_addr] <= ws_wdata;
      ws_rd_ff <= ws_mem_ff[rd_idx];
   end

   always_ff @(posedge clock) begin
      if (tally_we) tally_mem_ff[rd_idx] <= tally_new;
      tally_rd_ff <= tally_mem_ff[rd_idx];
   end

   // working registers
   always_ff @(posedge clock) begin
      if (pop) item_ff <= head_item;
      if (state_ff == kws_pkg::S_UPDATE) begin
         n_ff    <= tally_new.orders;
         qsum_ff <= tally_new.qty_sum;
         can_ff  <= tally_new.cancels;
      end
      if (state_ff == kws_pkg::S_MUL) begin
         prod_ff <= kws_pkg::PROD_W'(n_ff) * kws_pkg::PROD_W'(kws_pkg::NS_PER_SEC);
         op_ff   <= kws_pkg::OP_MOD;
      end
      if (state_ff == kws_pkg::S_OP && immediate) begin
         unique case (op_ff)
            kws_pkg::OP_MOD: op_ff <= kws_pkg::OP_AVG;
            kws_pkg::OP_AVG: begin
               avg_ff <= '0;
               op_ff  <= kws_pkg::OP_CAN;
            end
            kws_pkg::OP_CAN: begin
               canr_ff <= '0;
               op_ff   <= kws_pkg::OP_RATE;
            end
            default: rate_ff <= '1;
         endcase
      end
      if (state_ff == kws_pkg::S_WAIT && div_rsp.done) begin
         unique case (op_ff)
            kws_pkg::OP_MOD: op_ff <= kws_pkg::OP_AVG;
            kws_pkg::OP_AVG: begin
               avg_ff <= div_rsp.quot;
               op_ff  <= kws_pkg::OP_CAN;
            end
            kws_pkg::OP_CAN: begin
               canr_ff <= div_rsp.quot;
               op_ff   <= kws_pkg::OP_RATE;
            end
            default: rate_ff <= div_rsp.quot;
         endcase
      end
   end

   // result output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_load) begin
         rsp_out_slot         <= item_ff.slot;
         rsp_out_time_ns      <= item_ff.event_time_ns;
         rsp_out_book_seq     <= item_ff.book_seq;
         rsp_window_orders    <= n_ff;
         rsp_window_quantity  <= qsum_ff;
         rsp_avg_quantity_q16 <= avg_ff;
         rsp_cancel_ratio_q16 <= canr_ff;
         rsp_order_rate_q16   <= rate_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== design/keyed_tumbling_window_stats_top.sv =====
// top level of the keyed tumbling window stats block
//
// per-key tumbling window order statistics
// req channel: one order event word per handshake (valid/stall); the word is
//   taken at a clock edge with req_valid high and req_stall low
// rsp channel: zero or one feature record word per event, same handshake
// csr port: csr_wr_en writes csr_wdata into the register csr_index selects
//   (0 window length, 1 min orders, 2 emit period); write only when idle
// after reset the slot window table is swept to zero, one slot a cycle:
//   req_stall stays high for NUM_KEYS cycles
// events go into a two-word queue, then one at a time through the back end:
//   an event that stops before the emit test takes 4 back end cycles, a
//   nontrivial emit period adds 34 cycles (32 divider steps), and an emitted
//   record takes up to about 250 cycles in all (three 48 to 79 step divides
//   on the single bit-serial divider)
// a stalled rsp word holds; the queue keeps taking words until it is full
module keyed_tumbling_window_stats_top #(
   parameter int NUM_KEYS = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [kws_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [kws_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [kws_pkg::SLOT_W-1:0]        req_key_slot,
   input  logic [kws_pkg::TIME_W-1:0]        req_event_time_ns,
   input  logic [kws_pkg::STATUS_W-1:0]      req_order_status,
   input  logic [kws_pkg::QTY_W-1:0]         req_quantity,
   input  logic [kws_pkg::SEQ_W-1:0]         req_book_seq,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [kws_pkg::SLOT_W-1:0]        rsp_out_slot,
   output logic [kws_pkg::TIME_W-1:0]        rsp_out_time_ns,
   output logic [kws_pkg::SEQ_W-1:0]         rsp_out_book_seq,
   output logic [kws_pkg::CNT_W-1:0]         rsp_window_orders,
   output logic [kws_pkg::SUM_W-1:0]         rsp_window_quantity,
   output logic [kws_pkg::Q16_W-1:0]         rsp_avg_quantity_q16,
   output logic [kws_pkg::Q16_W-1:0]         rsp_cancel_ratio_q16,
   output logic [kws_pkg::Q16_W-1:0]         rsp_order_rate_q16
);

   kws_pkg::cfg_type        cfg_ff;
   kws_pkg::fifo_stat_type  fifo_stat;
   kws_pkg::item_type       push_item;
   kws_pkg::item_type       head_item;
   kws_pkg::div_req_type    div_req;
   kws_pkg::div_rsp_type    div_rsp;
   logic                    push;
   logic                    pop;
   logic                    clearing;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.window_length_ns <= kws_pkg::WLEN_RESET;
         cfg_ff.min_orders       <= kws_pkg::MINO_RESET;
         cfg_ff.emit_period      <= kws_pkg::PER_RESET;
      end else if (csr_wr_en) begin
         if (csr_index == kws_pkg::CSR_WINDOW_LENGTH) begin
            cfg_ff.window_length_ns <= csr_wdata;
         end else if (csr_index == kws_pkg::CSR_MIN_ORDERS) begin
            cfg_ff.min_orders <= csr_wdata[kws_pkg::MINO_W-1:0];
         end else if (csr_index == kws_pkg::CSR_EMIT_PERIOD) begin
            cfg_ff.emit_period <= csr_wdata[kws_pkg::PER_W-1:0];
         end
      end
   end

   // accept and classify
   kws_front #(.NUM_KEYS(NUM_KEYS)) u_front (
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_key_slot      (req_key_slot),
      .req_event_time_ns (req_event_time_ns),
      .req_order_status  (req_order_status),
      .req_quantity      (req_quantity),
      .req_book_seq      (req_book_seq),
      .clearing          (clearing),
      .fifo_stat         (fifo_stat),
      .push              (push),
      .push_item         (push_item)
   );

   // decoupling queue
   kws_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_item (push_item),
      .pop       (pop),
      .head_item (head_item),
      .stat      (fifo_stat)
   );

   // shared bit-serial divider
   kws_div u_div (
      .clock (clock),
      .reset (reset),
      .req   (div_req),
      .rsp   (div_rsp)
   );

   // slot update and record build
   kws_back #(.NUM_KEYS(NUM_KEYS)) u_back (
      .clock                (clock),
      .reset                (reset),
      .cfg                  (cfg_ff),
      .head_item            (head_item),
      .fifo_stat            (fifo_stat),
      .pop                  (pop),
      .clearing             (clearing),
      .div_req              (div_req),
      .div_rsp              (div_rsp),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_out_slot         (rsp_out_slot),
      .rsp_out_time_ns      (rsp_out_time_ns),
      .rsp_out_book_seq     (rsp_out_book_seq),
      .rsp_window_orders    (rsp_window_orders),
      .rsp_window_quantity  (rsp_window_quantity),
      .rsp_avg_quantity_q16 (rsp_avg_quantity_q16),
      .rsp_cancel_ratio_q16 (rsp_cancel_ratio_q16),
      .rsp_order_rate_q16   (rsp_order_rate_q16)
   );

endmodule

// ===== design/kws_checker.sv =====
// port-level checker for the keyed tumbling window stats block, with its bind
`include "keyed_tumbling_window_stats_top_assert.svh"

module kws_checker #(
   parameter int NUM_KEYS = 1024
) (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_stall,
   input logic                              rsp_valid,
   input logic                              rsp_stall,
   input logic [kws_pkg::SLOT_W-1:0]        rsp_out_slot,
   input logic [kws_pkg::CNT_W-1:0]         rsp_window_orders,
   input logic [kws_pkg::Q16_W-1:0]         rsp_avg_quantity_q16,
   input logic [kws_pkg::Q16_W-1:0]         rsp_cancel_ratio_q16,
   input logic [kws_pkg::Q16_W-1:0]         rsp_order_rate_q16
);

   // a stalled record word holds
   `KWS_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_out_slot) && $stable(rsp_window_orders) && $stable(rsp_order_rate_q16))

   // records only come from slots in range
   `KWS_ASSERT_NOW(a_slot_range, rsp_valid, 32'(rsp_out_slot) < NUM_KEYS)

   // no orders means zero average and cancel ratio
   `KWS_ASSERT_NOW(a_zero_orders, rsp_valid && rsp_window_orders == '0, rsp_avg_quantity_q16 == '0 && rsp_cancel_ratio_q16 == '0)

   // the table sweep after reset holds off requests
   `KWS_ASSERT_NOW(a_sweep_stall, $past(reset), req_stall)

endmodule

bind keyed_tumbling_window_stats_top kws_checker #(.NUM_KEYS(NUM_KEYS)) u_kws_checker (.*);
